FILE: rtl/core/pac_pkg.sv
// ----------------------------------------------------------------------------
// pac_pkg
// Shared widths, codes and the command type of the page allocation checker.
// ----------------------------------------------------------------------------
package pac_pkg;

  // field widths
  localparam int ADDR_W   = 32;
  localparam int ACTION_W = 2;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;
  localparam int PAGE_W   = 2;

  // parameter defaults
  localparam int NUM_PAGES_DEF = 1024;
  localparam int PAGE_SIZE_DEF = 32'h1000;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // record actions (the unused code behaves as a free)
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_HALTED   = 2'd3;

  // page states
  localparam logic [PAGE_W-1:0] PG_FREE     = 2'd0;
  localparam logic [PAGE_W-1:0] PG_ALLOC    = 2'd1;
  localparam logic [PAGE_W-1:0] PG_CONFLICT = 2'd2;

  // classified record handed from front to back (page index travels beside it)
  typedef struct packed {
    logic               is_read;
    logic               is_alloc;
    logic               oor;
    logic [COUNT_W-1:0] count;
    logic               last;
  } cmd_ctrl_t;

  // back-end sequencer states
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_WALK  = 5'b01000,
    S_DONE  = 5'b10000
  } back_state_t;

endpackage

FILE: rtl/core/pac_if.sv
// ----------------------------------------------------------------------------
// pac_in_if / pac_out_if
// Valid/ready channels for log records and for check results.
// ----------------------------------------------------------------------------
interface pac_in_if;
  import pac_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [ADDR_W-1:0]   page_address;
  logic [COUNT_W-1:0]  page_count;
  logic                last_record;

  modport source (output valid, action, page_address, page_count, last_record,
                  input ready);
  modport sink   (input valid, action, page_address, page_count, last_record,
                  output ready);
endinterface

interface pac_out_if;
  import pac_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   page_value;
  logic                end_reached;

  modport source (output valid, status, page_value, end_reached, input ready);
  modport sink   (input valid, status, page_value, end_reached, output ready);
endinterface

FILE: rtl/core/page_allocation_checker_top.sv
// ----------------------------------------------------------------------------
// page_allocation_checker_top
// Replays allocate, free and read records against a table of page states.
//
// in_ch carries one log record per transfer (action, page_address,
// page_count, last_record); out_ch returns one result per record (status,
// page_value, end_reached) in record order. cfg_we/cfg_wdata write the base
// address; the user must write it only while no record is in flight, which
// the block itself does not enforce.
// The back end takes a record from the queue, walks its run, reads its page
// or settles it without the table, and loads the result; it takes a new
// record only once that result is in the output register. The page table
// has one read and one write port and the walk writes one page and reads
// the next per cycle. A two-entry queue lets records be accepted while the
// back end walks a run or a result waits for out_ch.ready; when the queue
// is full in_ch.ready drops. A stalled result holds in the output register
// and holds the back end once its walk is done. After reset the page table
// is cleared to free, one page per cycle; in_ch.ready stays low until then.
// PAGE_SIZE must be a power of two; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module page_allocation_checker_top #(
  parameter int NUM_PAGES = pac_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SIZE = pac_pkg::PAGE_SIZE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pac_pkg::ADDR_W-1:0] cfg_wdata,
  pac_in_if.sink                     in_ch,
  pac_out_if.source                  out_ch
);
  import pac_pkg::*;

  localparam int IDX_W  = $clog2(NUM_PAGES);
  localparam int CMD_W  = $bits(cmd_ctrl_t) + IDX_W;

  logic             init_done;
  logic             fq_valid, fq_ready;
  cmd_ctrl_t        fq_ctrl;
  logic [IDX_W-1:0] fq_idx;
  logic             bq_valid, bq_ready;
  cmd_ctrl_t        bq_ctrl;
  logic [IDX_W-1:0] bq_idx;
  logic [CMD_W-1:0] fq_data, bq_data;

  // front: base address, page index and classification
  pac_front #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_SIZE (PAGE_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .init_done (init_done),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_ctrl    (fq_ctrl),
    .q_idx     (fq_idx)
  );

  // command queue between front and back
  assign fq_data = {fq_ctrl, fq_idx};

  pac_cmd_queue #(
    .DATA_W (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (bq_valid),
    .out_ready (bq_ready),
    .out_data  (bq_data)
  );

  assign bq_ctrl = bq_data[CMD_W-1:IDX_W];
  assign bq_idx  = bq_data[IDX_W-1:0];

  // back: page table walk and results
  pac_back #(
    .NUM_PAGES (NUM_PAGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (bq_valid),
    .q_ready   (bq_ready),
    .q_ctrl    (bq_ctrl),
    .q_idx     (bq_idx),
    .init_done (init_done),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/core/pac_front.sv
// ----------------------------------------------------------------------------
// pac_front
// Holds the base address, turns a record's address into a page index and
// classifies the record as read or run, in range or out of range.
// ----------------------------------------------------------------------------
module pac_front #(
  parameter int NUM_PAGES = pac_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SIZE = pac_pkg::PAGE_SIZE_DEF,
  localparam int IDX_W    = $clog2(NUM_PAGES)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pac_pkg::ADDR_W-1:0] cfg_wdata,
  pac_in_if.sink                    in_ch,
  input  logic                      init_done,
  output logic                      q_valid,
  input  logic                      q_ready,
  output pac_pkg::cmd_ctrl_t        q_ctrl,
  output logic [IDX_W-1:0]          q_idx
);
  import pac_pkg::*;

  // page size is a power of two, so the divide is a shift
  localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam logic [ADDR_W:0] PAGE_LIMIT = (ADDR_W+1)'(NUM_PAGES);

  logic [ADDR_W-1:0] base_r;
  logic              below;
  logic              is_read;
  logic [ADDR_W-1:0] offset;
  logic [ADDR_W-1:0] page_idx;
  logic [ADDR_W:0]   run_end;
  logic              oor;

  // base address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  // page index and range check
  assign below    = in_ch.page_address < base_r;
  assign offset   = in_ch.page_address - base_r;
  assign page_idx = offset >> PAGE_SHIFT;
  assign run_end  = {1'b0, page_idx} + (ADDR_W+1)'(in_ch.page_count);
  assign is_read  = (in_ch.action == ACT_READ);

  always_comb begin
    if (below) begin
      oor = 1'b1;
    end else if (is_read) begin
      oor = ({1'b0, page_idx} >= PAGE_LIMIT);
    end else begin
      oor = (run_end > PAGE_LIMIT);
    end
  end

  // classified record into the queue, held off during the table clear
  assign q_ctrl.is_read  = is_read;
  assign q_ctrl.is_alloc = (in_ch.action == ACT_ALLOC);
  assign q_ctrl.oor      = oor;
  assign q_ctrl.count    = in_ch.page_count;
  assign q_ctrl.last     = in_ch.last_record;
  assign q_idx           = page_idx[IDX_W-1:0];
  assign q_valid         = in_ch.valid && init_done;
  assign in_ch.ready     = q_ready && init_done;

endmodule

FILE: rtl/core/pac_cmd_queue.sv
// ----------------------------------------------------------------------------
// pac_cmd_queue
// Small first-in first-out queue of classified records between front and back.
// ----------------------------------------------------------------------------
module pac_cmd_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);
  import pac_pkg::*;

  // depth is a power of two, so the pointers wrap on their own
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push, pop;

  assign in_ready  = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_data;
    end
  end

endmodule

FILE: rtl/core/pac_back.sv
// ----------------------------------------------------------------------------
// pac_back
// Page table and sequencer: clears the table after reset, walks each run one
// page per cycle, serves reads and keeps the sticky flags and the result.
// ----------------------------------------------------------------------------
module pac_back #(
  parameter int NUM_PAGES = pac_pkg::NUM_PAGES_DEF,
  localparam int IDX_W    = $clog2(NUM_PAGES)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  pac_pkg::cmd_ctrl_t q_ctrl,
  input  logic [IDX_W-1:0]   q_idx,
  output logic               init_done,
  pac_out_if.source          out_ch
);
  import pac_pkg::*;

  localparam logic [IDX_W-1:0] LAST_PAGE = IDX_W'(NUM_PAGES - 1);

  // page table
  logic [PAGE_W-1:0] mem [NUM_PAGES];
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [PAGE_W-1:0] mem_wdata;
  logic [PAGE_W-1:0] mem_rdata_r;

  back_state_t        state_r, state_nxt;
  cmd_ctrl_t          cmd_r, cmd_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic               conflict_flag_r, conflict_flag_nxt;
  logic               range_flag_r, range_flag_nxt;
  logic               end_flag_r, end_flag_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [PAGE_W-1:0]  res_value_r, res_value_nxt;
  logic               res_end_r, res_end_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [PAGE_W-1:0]  out_value_r, out_value_nxt;
  logic               out_end_r, out_end_nxt;
  logic               halted;
  logic [PAGE_W-1:0]  page_new;
  logic               page_hit;
  logic               hit_any;

  assign halted    = conflict_flag_r || range_flag_r || end_flag_r;
  assign hit_any   = hit_r || page_hit;
  assign init_done = (state_r != S_CLEAR);

  // page transition for the run being walked
  always_comb begin
    page_hit = 1'b0;
    if (cmd_r.is_alloc && mem_rdata_r == PG_FREE) begin
      page_new = PG_ALLOC;
    end else if (!cmd_r.is_alloc && mem_rdata_r == PG_ALLOC) begin
      page_new = PG_FREE;
    end else begin
      page_new = PG_CONFLICT;
      page_hit = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt         = state_r;
    cmd_nxt           = cmd_r;
    cur_nxt           = cur_r;
    rem_nxt           = rem_r;
    hit_nxt           = hit_r;
    clr_nxt           = clr_r;
    conflict_flag_nxt = conflict_flag_r;
    range_flag_nxt    = range_flag_r;
    end_flag_nxt      = end_flag_r;
    res_status_nxt    = res_status_r;
    res_value_nxt     = res_value_r;
    res_end_nxt       = res_end_r;
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    out_status_nxt    = out_status_r;
    out_value_nxt     = out_value_r;
    out_end_nxt       = out_end_r;
    q_ready           = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = cur_r;
    mem_wdata         = page_new;
    mem_re            = 1'b0;
    mem_raddr         = q_idx;

    unique case (state_r)
      // one table entry per cycle back to free
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = PG_FREE;
        clr_nxt   = clr_r + IDX_W'(1);
        if (clr_r == LAST_PAGE) begin
          state_nxt = S_IDLE;
        end
      end

      // take a record and decide how it is served
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_nxt        = q_ctrl;
          cur_nxt        = q_idx;
          rem_nxt        = q_ctrl.count;
          hit_nxt        = 1'b0;
          res_status_nxt = ST_OK;
          res_value_nxt  = PG_FREE;
          res_end_nxt    = end_flag_r;
          if (q_ctrl.is_read) begin
            if (q_ctrl.oor) begin
              res_status_nxt = ST_RANGE;
              state_nxt      = S_DONE;
            end else begin
              mem_re    = 1'b1;
              state_nxt = S_READ;
            end
          end else if (halted) begin
            res_status_nxt = ST_HALTED;
            state_nxt      = S_DONE;
          end else if (q_ctrl.oor) begin
            range_flag_nxt = 1'b1;
            res_status_nxt = ST_RANGE;
            state_nxt      = S_DONE;
          end else if (q_ctrl.count == '0) begin
            end_flag_nxt = end_flag_r || q_ctrl.last;
            res_end_nxt  = end_flag_r || q_ctrl.last;
            state_nxt    = S_DONE;
          end else begin
            mem_re    = 1'b1;
            state_nxt = S_WALK;
          end
        end
      end

      // read data of one page is back
      S_READ: begin
        res_value_nxt = mem_rdata_r;
        state_nxt     = S_DONE;
      end

      // update the current page and fetch the next
      S_WALK: begin
        mem_we  = 1'b1;
        hit_nxt = hit_any;
        if (rem_r == COUNT_W'(1)) begin
          conflict_flag_nxt = conflict_flag_r || hit_any;
          res_status_nxt    = hit_any ? ST_CONFLICT : ST_OK;
          end_flag_nxt      = end_flag_r || cmd_r.last;
          res_end_nxt       = end_flag_r || cmd_r.last;
          state_nxt         = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cur_r + IDX_W'(1);
          cur_nxt   = cur_r + IDX_W'(1);
          rem_nxt   = rem_r - COUNT_W'(1);
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_end_nxt    = res_end_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_r           <= '0;
      conflict_flag_r <= 1'b0;
      range_flag_r    <= 1'b0;
      end_flag_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      clr_r           <= clr_nxt;
      conflict_flag_r <= conflict_flag_nxt;
      range_flag_r    <= range_flag_nxt;
      end_flag_r      <= end_flag_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    cur_r        <= cur_nxt;
    rem_r        <= rem_nxt;
    hit_r        <= hit_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_end_r    <= res_end_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_end_r    <= out_end_nxt;
  end

  // page table ports, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.page_value  = out_value_r;
  assign out_ch.end_reached = out_end_r;

  // no result leaves while the table is being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r)
    else $error("result valid during table clear");

  // a run is only walked while no flag halts the block
  a_walk_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> !(conflict_flag_r || range_flag_r || end_flag_r))
    else $error("page walk while halted");

  // the walk always has pages left
  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (rem_r != '0))
    else $error("page walk with empty run");

  // sticky flags never drop
  a_conflict_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    conflict_flag_r |=> conflict_flag_r)
    else $error("conflict flag dropped");

  a_range_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    range_flag_r |=> range_flag_r)
    else $error("range flag dropped");

endmodule

FILE: tb/tb_page_allocation_checker_top.sv
// ----------------------------------------------------------------------------
// tb_page_allocation_checker_top
// Self-checking bench for the page allocation checker. It replays allocate,
// free and read records under several base addresses and handshake patterns.
// A private copy of the page table predicts every result, and each result
// transfer is compared in order. Most records form a clean log. The run ends
// with one record that halts the log, chosen at random, and then noise.
// ----------------------------------------------------------------------------
module tb_page_allocation_checker_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pac_pkg::*;

  localparam int NUM_PAGES   = NUM_PAGES_DEF;
  localparam int PAGE_SIZE   = PAGE_SIZE_DEF;
  localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
  localparam int CYCLE_LIMIT = 6_000_000;

  // unused action code, the block treats it as a free
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam logic [ADDR_W-1:0]   ADDR_MAX  = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_value;
    logic                end_reached;
  } page_result_t;

  typedef enum {
    HALT_CONFLICT,
    HALT_CONFLICT_LAST,
    HALT_OVERRUN,
    HALT_BELOW_BASE,
    HALT_LOG_END
  } halt_cause_e;

  // private page table, sticky flags and the results still owed by the block
  class page_table_scoreboard;
    logic [PAGE_W-1:0] pages [NUM_PAGES];
    logic [ADDR_W-1:0] base;
    bit                conflict_seen;
    bit                range_seen;
    bit                end_seen;
    page_result_t      expected_results[$];
    int unsigned       checked;
    int unsigned       errors;
    int unsigned       pages_walked;

    function new();
      foreach (pages[i]) pages[i] = PG_FREE;
      base = '0;
    endfunction

    // apply one accepted record to the table and queue its result
    function void note_record(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
                              logic [COUNT_W-1:0] cnt, logic last);
      page_result_t      r;
      logic [ADDR_W-1:0] offset;
      longint            first;
      bit                in_reach;
      bit                hit;
      r        = '{status: ST_OK, page_value: PG_FREE, end_reached: 1'b0};
      in_reach = (addr >= base);
      offset   = addr - base;
      first    = in_reach ? offset / PAGE_SIZE : 0;
      hit      = 1'b0;
      if (act == ACT_READ) begin
        if (in_reach && first < NUM_PAGES) r.page_value = pages[first];
        else r.status = ST_RANGE;
      end else if (conflict_seen || range_seen || end_seen) begin
        r.status = ST_HALTED;
      end else if (!in_reach || first + cnt > NUM_PAGES) begin
        range_seen = 1'b1;
        r.status   = ST_RANGE;
      end else begin
        // walk the run, bad transitions mark the page and keep going
        for (int i = 0; i < cnt; i++) begin
          if (act == ACT_ALLOC && pages[first + i] == PG_FREE) begin
            pages[first + i] = PG_ALLOC;
          end else if (act != ACT_ALLOC && pages[first + i] == PG_ALLOC) begin
            pages[first + i] = PG_FREE;
          end else begin
            pages[first + i] = PG_CONFLICT;
            hit = 1'b1;
          end
        end
        pages_walked += cnt;
        if (hit) begin
          conflict_seen = 1'b1;
          r.status      = ST_CONFLICT;
        end
        if (last) end_seen = 1'b1;
      end
      r.end_reached = end_seen;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(page_result_t got);
      page_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status=%0d value=%0d end=%0d",
                 $time, got.status, got.page_value, got.end_reached);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      checked++;
      compare_field("status", want.status, got.status);
      compare_field("page_value", want.page_value, got.page_value);
      compare_field("end_reached", {1'b0, want.end_reached}, {1'b0, got.end_reached});
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  pac_in_if  in_ch ();
  pac_out_if out_ch ();

  page_table_scoreboard sb = new();

  int          sender_idle_pct = 0;
  int          recv_stall_pct  = 0;
  int unsigned records_sent    = 0;
  int unsigned cycles          = 0;
  halt_cause_e cause;
  page_result_t seen;

  page_allocation_checker_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time,
               sb.expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver back-pressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen.status      = out_ch.status;
        seen.page_value  = out_ch.page_value;
        seen.end_reached = out_ch.end_reached;
        sb.check_result(seen);
      end
    end
  end

  // highest page index whose address still fits in 32 bits, capped
  function automatic longint top_page(longint cap);
    longint reach;
    reach = (ADDR_MAX - sb.base) / PAGE_SIZE;
    return (reach < cap) ? reach : cap;
  endfunction

  // byte address somewhere inside page idx of the current base
  function automatic logic [ADDR_W-1:0] page_addr(longint idx);
    longint            room;
    logic [ADDR_W-1:0] a;
    room = ADDR_MAX - sb.base - idx * PAGE_SIZE;
    if (room > PAGE_SIZE - 1) room = PAGE_SIZE - 1;
    a = ADDR_W'(sb.base + idx * PAGE_SIZE + $urandom_range(int'(room)));
    return a;
  endfunction

  // one record transfer, with optional idle cycles in front
  task automatic send_record(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
                             logic [COUNT_W-1:0] cnt, logic last);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.page_address <= addr;
    in_ch.page_count   <= cnt;
    in_ch.last_record  <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_record(act, addr, cnt, last);
    records_sent++;
  endtask

  // base address write once every result is back
  task automatic write_base(logic [ADDR_W-1:0] value);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we  <= 1'b0;
    sb.base  = value;
  endtask

  // run that is legal against the current table: direction follows the
  // state of the start page, length stops at the first page that differs
  task automatic send_legal_run();
    longint            start;
    int                want;
    int                n;
    int                r;
    logic [PAGE_W-1:0] st;
    logic [ACTION_W-1:0] act;
    start = $urandom_range(int'(top_page(NUM_PAGES - 1)));
    r     = $urandom_range(99);
    if (r < 70) want = $urandom_range(8, 1);
    else if (r < 95) want = $urandom_range(64, 9);
    else want = $urandom_range(NUM_PAGES, 65);
    st = sb.pages[start];
    n  = 0;
    while (n < want && start + n < NUM_PAGES && sb.pages[start + n] == st) n++;
    if (st == PG_FREE) act = ACT_ALLOC;
    else act = $urandom_range(1) ? ACT_FREE : ACT_SPARE;
    send_record(act, page_addr(start), COUNT_W'(n), 1'b0);
  endtask

  // mostly clean runs, with reads and empty runs mixed in
  task automatic run_random_records(int n);
    int                  pick;
    logic [ADDR_W-1:0]   addr;
    logic [ACTION_W-1:0] act;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_legal_run();
      end else if (pick < 92) begin
        if ($urandom_range(3) == 0) addr = $urandom;
        else addr = page_addr($urandom_range(int'(top_page(NUM_PAGES - 1))));
        send_record(ACT_READ, addr, COUNT_W'($urandom_range(COUNT_MAX)),
                    1'($urandom_range(1)));
      end else begin
        case ($urandom_range(2))
          0:       act = ACT_ALLOC;
          1:       act = ACT_FREE;
          default: act = ACT_SPARE;
        endcase
        send_record(act, page_addr($urandom_range(int'(top_page(NUM_PAGES)))), '0, 1'b0);
      end
    end
  endtask

  initial begin
    int                spot;
    logic [ADDR_W-1:0] addr;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_ALLOC;
    in_ch.page_address = '0;
    in_ch.page_count   = '0;
    in_ch.last_record  = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    rst_n              = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed records, none of them halts the log
    write_base(32'h0001_0000);
    send_record(ACT_READ, page_addr(0), '0, 1'b0);
    send_record(ACT_READ, $urandom_range(32'hFFFF), '0, 1'b1);  // read below base
    send_record(ACT_READ, ADDR_MAX, '0, 1'b0);                  // read far past the table
    send_record(ACT_READ, page_addr(NUM_PAGES - 1), '0, 1'b0);
    send_record(ACT_READ, page_addr(NUM_PAGES), '0, 1'b0);      // first page past the table
    send_record(ACT_ALLOC, page_addr(0), 11'd1, 1'b0);
    send_record(ACT_ALLOC, page_addr(1), 11'd16, 1'b0);
    send_record(ACT_READ, page_addr(5), '0, 1'b0);
    send_record(ACT_FREE, page_addr(0), 11'd1, 1'b0);
    send_record(ACT_SPARE, page_addr(1), 11'd16, 1'b0);
    send_record(ACT_READ, page_addr(1), '0, 1'b0);
    send_record(ACT_FREE, page_addr(500), '0, 1'b0);            // empty run
    send_record(ACT_ALLOC, page_addr(NUM_PAGES), '0, 1'b0);     // empty run at the table end
    send_record(ACT_ALLOC, page_addr(NUM_PAGES - 1), 11'd1, 1'b0);
    send_record(ACT_FREE, page_addr(NUM_PAGES - 1), 11'd1, 1'b0);
    send_record(ACT_ALLOC, page_addr(0), COUNT_W'(NUM_PAGES), 1'b0);  // whole table
    send_record(ACT_READ, page_addr(700), '0, 1'b0);
    send_record(ACT_SPARE, page_addr(0), COUNT_W'(NUM_PAGES), 1'b0);

    // random phases over several bases and handshake patterns
    run_random_records(150);

    write_base('0);
    sender_idle_pct = 84;
    run_random_records(150);

    write_base($urandom_range(32'hFFBF_FFFF));
    sender_idle_pct = 0;
    recv_stall_pct  = 84;
    run_random_records(150);

    // table only partly reachable below the top of the address space
    write_base(32'hFFF0_0000 | $urandom_range(32'h000F_FFFF));
    sender_idle_pct = 31;
    recv_stall_pct  = 31;
    run_random_records(150);

    // only page zero is reachable
    write_base(ADDR_MAX);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    run_random_records(40);

    // one record halts the log for good, then noise
    write_base($urandom_range(32'hFF00_0000, 32'h0000_1000));
    sender_idle_pct = 31;
    recv_stall_pct  = 31;
    cause = halt_cause_e'($urandom_range(HALT_LOG_END));
    spot  = $urandom_range(NUM_PAGES - 4);
    case (cause)
      HALT_CONFLICT, HALT_CONFLICT_LAST: begin
        // run in the wrong direction for the start page
        send_record((sb.pages[spot] == PG_ALLOC) ? ACT_ALLOC : ACT_FREE, page_addr(spot),
                    COUNT_W'($urandom_range(4, 1)), cause == HALT_CONFLICT_LAST);
      end
      HALT_OVERRUN: begin
        send_record($urandom_range(1) ? ACT_ALLOC : ACT_FREE, page_addr(spot),
                    COUNT_W'($urandom_range(COUNT_MAX, NUM_PAGES - spot + 1)),
                    1'($urandom_range(1)));
      end
      HALT_BELOW_BASE: begin
        send_record(ACT_ALLOC, $urandom_range(sb.base - 1), COUNT_W'($urandom_range(8)),
                    1'($urandom_range(1)));
      end
      default: begin
        send_record(ACT_ALLOC, page_addr(spot), '0, 1'b1);
      end
    endcase
    send_record(ACT_ALLOC, page_addr(spot), 11'd1, 1'b0);
    send_record(ACT_READ, page_addr(spot), '0, 1'b0);
    repeat (40) begin
      if ($urandom_range(1)) addr = $urandom;
      else addr = page_addr($urandom_range(NUM_PAGES - 1));
      send_record(ACTION_W'($urandom_range(3)), addr, COUNT_W'($urandom_range(COUNT_MAX)),
                  1'($urandom_range(1)));
    end

    // drain, then watch for stray results
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d records under six base settings, %0d results checked,",
             records_sent, sb.checked);
    $display("%0d pages walked; log halted by %s.", sb.pages_walked, cause.name());
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: page_allocation_checker_top.f
rtl/core/pac_pkg.sv
rtl/core/pac_if.sv
rtl/core/pac_front.sv
rtl/core/pac_cmd_queue.sv
rtl/core/pac_back.sv
rtl/core/page_allocation_checker_top.sv
tb/tb_page_allocation_checker_top.sv
